>>> rtl/core/sts_pkg.sv
// Shared types, character codes, token kinds and keyword table of the token scanner.
`default_nettype none

package sts_pkg;

    typedef enum logic [10:0] {
        MODE_IDLE    = 11'b000_0000_0001,
        MODE_IDENT   = 11'b000_0000_0010,
        MODE_NUMBER  = 11'b000_0000_0100,
        MODE_NUMDOT  = 11'b000_0000_1000,
        MODE_STRING  = 11'b000_0001_0000,
        MODE_COMMENT = 11'b000_0010_0000,
        MODE_SLASH   = 11'b000_0100_0000,
        MODE_BANG    = 11'b000_1000_0000,
        MODE_EQUAL   = 11'b001_0000_0000,
        MODE_GREATER = 11'b010_0000_0000,
        MODE_LESS    = 11'b100_0000_0000
    } mode_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_EQ     = 8'h3d;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5a;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_USCORE = 8'h5f;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7a;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    localparam logic [5:0] KIND_LPAREN   = 6'd0;
    localparam logic [5:0] KIND_RPAREN   = 6'd1;
    localparam logic [5:0] KIND_LBRACE   = 6'd2;
    localparam logic [5:0] KIND_RBRACE   = 6'd3;
    localparam logic [5:0] KIND_LBRACK   = 6'd4;
    localparam logic [5:0] KIND_RBRACK   = 6'd5;
    localparam logic [5:0] KIND_COMMA    = 6'd6;
    localparam logic [5:0] KIND_DOT      = 6'd7;
    localparam logic [5:0] KIND_SEMI     = 6'd8;
    localparam logic [5:0] KIND_MINUS    = 6'd9;
    localparam logic [5:0] KIND_PLUS     = 6'd10;
    localparam logic [5:0] KIND_SLASH    = 6'd11;
    localparam logic [5:0] KIND_STAR     = 6'd12;
    localparam logic [5:0] KIND_BANG_EQ  = 6'd13;
    localparam logic [5:0] KIND_EQ       = 6'd14;
    localparam logic [5:0] KIND_EQ_EQ    = 6'd15;
    localparam logic [5:0] KIND_GT       = 6'd16;
    localparam logic [5:0] KIND_GT_EQ    = 6'd17;
    localparam logic [5:0] KIND_LT       = 6'd18;
    localparam logic [5:0] KIND_LT_EQ    = 6'd19;
    localparam logic [5:0] KIND_IDENT    = 6'd20;
    localparam logic [5:0] KIND_STRING   = 6'd21;
    localparam logic [5:0] KIND_NUMBER   = 6'd22;
    localparam logic [5:0] KIND_AND      = 6'd23;
    localparam logic [5:0] KIND_ELSE     = 6'd24;
    localparam logic [5:0] KIND_FALSE    = 6'd25;
    localparam logic [5:0] KIND_FOR      = 6'd26;
    localparam logic [5:0] KIND_FUNCTION = 6'd27;
    localparam logic [5:0] KIND_IF       = 6'd28;
    localparam logic [5:0] KIND_NOT      = 6'd29;
    localparam logic [5:0] KIND_OR       = 6'd30;
    localparam logic [5:0] KIND_RETURN   = 6'd31;
    localparam logic [5:0] KIND_STRUCT   = 6'd32;
    localparam logic [5:0] KIND_SUPER    = 6'd33;
    localparam logic [5:0] KIND_THIS     = 6'd34;
    localparam logic [5:0] KIND_TRUE     = 6'd35;
    localparam logic [5:0] KIND_VAR      = 6'd36;
    localparam logic [5:0] KIND_WHILE    = 6'd37;
    localparam logic [5:0] KIND_COMMENT  = 6'd38;
    localparam logic [5:0] KIND_INVALID  = 6'd39;
    localparam logic [5:0] KIND_END      = 6'd40;

    // keyword text, first character in the low byte
    localparam int KW_COUNT = 15;
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0000_0064_6e61, 64'h0000_0000_6573_6c65, 64'h0000_0065_736c_6166,
        64'h0000_0000_0072_6f66, 64'h6e6f_6974_636e_7566, 64'h0000_0000_0000_6669,
        64'h0000_0000_0074_6f6e, 64'h0000_0000_0000_726f, 64'h0000_6e72_7574_6572,
        64'h0000_7463_7572_7473, 64'h0000_0072_6570_7573, 64'h0000_0000_7369_6874,
        64'h0000_0000_6575_7274, 64'h0000_0000_0072_6176, 64'h0000_0065_6c69_6877
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd4, 4'd5, 4'd3, 4'd8, 4'd2, 4'd3, 4'd2,
        4'd6, 4'd6, 4'd5, 4'd4, 4'd4, 4'd3, 4'd5
    };
    localparam logic [5:0] KW_KIND [KW_COUNT] = '{
        KIND_AND, KIND_ELSE, KIND_FALSE, KIND_FOR, KIND_FUNCTION, KIND_IF,
        KIND_NOT, KIND_OR, KIND_RETURN, KIND_STRUCT, KIND_SUPER, KIND_THIS,
        KIND_TRUE, KIND_VAR, KIND_WHILE
    };

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = 3;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
    } token_t;

    // all tokens caused by one input byte
    typedef struct packed {
        logic [1:0] count;
        token_t     tok2;
        token_t     tok1;
        token_t     tok0;
    } bundle_t;

    function automatic logic numeral_char(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic letter_char(input logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ))
            || (c == CH_USCORE);
    endfunction

    // whole-word keyword match; len of zero never matches
    function automatic logic [5:0] word_kind(input logic [63:0] word, input logic [3:0] len);
        logic [63:0] mask;
        logic [5:0]  kind;
        mask = ~(64'hFFFF_FFFF_FFFF_FFFF << {len, 3'b000});
        kind = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if ((len == KW_LEN[i]) && (((word ^ KW_TEXT[i]) & mask) == 64'd0))
            begin
                kind = KW_KIND[i];
            end
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/sts_scan.sv
// Front end: per-byte classification, scan state and token bundle generation.
`default_nettype none

module sts_scan #(
    parameter int POSITION_BITS = 16,
    parameter int KEYWORD_BYTES = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      in_byte,
    output sts_pkg::bundle_t     bundle
);

    localparam int PB       = POSITION_BITS;
    localparam int IDX_BITS = $clog2(KEYWORD_BYTES);
    localparam logic [PB-1:0] POS_MAX = '1;
    localparam logic [PB-1:0] ONE     = PB'(1);
    localparam logic [PB-1:0] TWO     = PB'(2);
    localparam logic [PB-1:0] KW_LIM  = PB'(KEYWORD_BYTES);
    localparam logic [PB-1:0] KW_MAX  = PB'(8);

    sts_pkg::mode_t mode_reg, mode_next;
    logic [PB-1:0]  pos_reg, pos_next;
    logic [PB-1:0]  start_reg, start_next;
    logic [PB-1:0]  len_reg, len_next;
    logic           frac_reg, frac_next;
    logic [7:0]     prefix_reg [KEYWORD_BYTES];

    logic                wr_en;
    logic [IDX_BITS-1:0] wr_idx;
    logic                fresh;
    logic                ended;
    logic                va, vb, vc;
    sts_pkg::token_t     ta, tb, tc;
    logic [63:0]         word;
    logic [3:0]          word_len;

    function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
        return (v == POS_MAX) ? v : v + ONE;
    endfunction

    function automatic logic [PB-1:0] floor_dec(input logic [PB-1:0] v);
        return (v == '0) ? v : v - ONE;
    endfunction

    function automatic sts_pkg::token_t make_tok(input logic [5:0] k,
                                                 input logic [PB-1:0] s,
                                                 input logic [PB-1:0] l);
        sts_pkg::token_t t;
        t.kind   = k;
        t.start  = 16'(s);
        t.length = 16'(l);
        return t;
    endfunction

    assign word = {prefix_reg[7], prefix_reg[6], prefix_reg[5], prefix_reg[4],
                   prefix_reg[3], prefix_reg[2], prefix_reg[1], prefix_reg[0]};
    assign word_len = (len_reg <= KW_MAX) ? len_reg[3:0] : 4'd0;

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = sat_inc(pos_reg);
        start_next = start_reg;
        len_next   = len_reg;
        frac_next  = frac_reg;
        wr_en      = 1'b0;
        wr_idx     = len_reg[IDX_BITS-1:0];
        fresh      = 1'b0;
        ended      = 1'b0;
        va         = 1'b0;
        vb         = 1'b0;
        vc         = 1'b0;
        ta         = make_tok(sts_pkg::KIND_INVALID, start_reg, len_reg);
        tb         = make_tok(sts_pkg::KIND_DOT, floor_dec(pos_reg), ONE);
        tc         = make_tok(sts_pkg::KIND_INVALID, pos_reg, ONE);

        // open token: extend it or close it
        unique case (mode_reg)
            sts_pkg::MODE_IDENT:
            begin
                if (sts_pkg::letter_char(in_byte) || sts_pkg::numeral_char(in_byte))
                begin
                    wr_en    = (len_reg < KW_LIM);
                    len_next = sat_inc(len_reg);
                end
                else
                begin
                    va    = 1'b1;
                    ta    = make_tok(sts_pkg::word_kind(word, word_len), start_reg, len_reg);
                    fresh = 1'b1;
                end
            end
            sts_pkg::MODE_NUMBER:
            begin
                if (sts_pkg::numeral_char(in_byte))
                begin
                    len_next = sat_inc(len_reg);
                end
                else if ((in_byte == sts_pkg::CH_DOT) && !frac_reg)
                begin
                    len_next  = sat_inc(len_reg);
                    mode_next = sts_pkg::MODE_NUMDOT;
                end
                else
                begin
                    va    = 1'b1;
                    ta    = make_tok(sts_pkg::KIND_NUMBER, start_reg, len_reg);
                    fresh = 1'b1;
                end
            end
            sts_pkg::MODE_NUMDOT:
            begin
                if (sts_pkg::numeral_char(in_byte))
                begin
                    frac_next = 1'b1;
                    len_next  = sat_inc(len_reg);
                    mode_next = sts_pkg::MODE_NUMBER;
                end
                else
                begin
                    // dot was not a fraction: number, then the dot on its own
                    va    = 1'b1;
                    ta    = make_tok(sts_pkg::KIND_NUMBER, start_reg, floor_dec(len_reg));
                    vb    = 1'b1;
                    fresh = 1'b1;
                end
            end
            sts_pkg::MODE_STRING:
            begin
                if (in_byte == sts_pkg::CH_NUL)
                begin
                    va    = 1'b1;
                    ta    = make_tok(sts_pkg::KIND_INVALID, start_reg, len_reg);
                    fresh = 1'b1;
                end
                else
                begin
                    len_next = sat_inc(len_reg);
                    if (in_byte == sts_pkg::CH_QUOTE)
                    begin
                        va        = 1'b1;
                        ta        = make_tok(sts_pkg::KIND_STRING, start_reg, sat_inc(len_reg));
                        mode_next = sts_pkg::MODE_IDLE;
                    end
                end
            end
            sts_pkg::MODE_COMMENT:
            begin
                if ((in_byte == sts_pkg::CH_LF) || (in_byte == sts_pkg::CH_NUL))
                begin
                    va    = 1'b1;
                    ta    = make_tok(sts_pkg::KIND_COMMENT, start_reg, len_reg);
                    fresh = 1'b1;
                end
                else
                begin
                    len_next = sat_inc(len_reg);
                end
            end
            sts_pkg::MODE_SLASH:
            begin
                if (in_byte == sts_pkg::CH_SLASH)
                begin
                    len_next  = TWO;
                    mode_next = sts_pkg::MODE_COMMENT;
                end
                else
                begin
                    va    = 1'b1;
                    ta    = make_tok(sts_pkg::KIND_SLASH, start_reg, ONE);
                    fresh = 1'b1;
                end
            end
            sts_pkg::MODE_BANG, sts_pkg::MODE_EQUAL, sts_pkg::MODE_GREATER,
            sts_pkg::MODE_LESS:
            begin
                va = 1'b1;
                if (in_byte == sts_pkg::CH_EQ)
                begin
                    mode_next = sts_pkg::MODE_IDLE;
                    unique case (mode_reg)
                        sts_pkg::MODE_BANG:    ta = make_tok(sts_pkg::KIND_BANG_EQ, start_reg, TWO);
                        sts_pkg::MODE_EQUAL:   ta = make_tok(sts_pkg::KIND_EQ_EQ, start_reg, TWO);
                        sts_pkg::MODE_GREATER: ta = make_tok(sts_pkg::KIND_GT_EQ, start_reg, TWO);
                        default:               ta = make_tok(sts_pkg::KIND_LT_EQ, start_reg, TWO);
                    endcase
                end
                else
                begin
                    fresh = 1'b1;
                    unique case (mode_reg)
                        sts_pkg::MODE_BANG:    ta = make_tok(sts_pkg::KIND_INVALID, start_reg, ONE);
                        sts_pkg::MODE_EQUAL:   ta = make_tok(sts_pkg::KIND_EQ, start_reg, ONE);
                        sts_pkg::MODE_GREATER: ta = make_tok(sts_pkg::KIND_GT, start_reg, ONE);
                        default:               ta = make_tok(sts_pkg::KIND_LT, start_reg, ONE);
                    endcase
                end
            end
            default:
            begin
                fresh = 1'b1;
            end
        endcase

        // byte seen with no token open
        if (fresh)
        begin
            mode_next = sts_pkg::MODE_IDLE;
            vc        = 1'b1;
            unique case (in_byte) inside
                sts_pkg::CH_NUL:
                begin
                    tc    = make_tok(sts_pkg::KIND_END, pos_reg, ONE);
                    ended = 1'b1;
                end
                sts_pkg::CH_SP, sts_pkg::CH_TAB, sts_pkg::CH_LF, sts_pkg::CH_CR:
                    vc = 1'b0;
                sts_pkg::CH_LPAREN: tc = make_tok(sts_pkg::KIND_LPAREN, pos_reg, ONE);
                sts_pkg::CH_RPAREN: tc = make_tok(sts_pkg::KIND_RPAREN, pos_reg, ONE);
                sts_pkg::CH_LBRACE: tc = make_tok(sts_pkg::KIND_LBRACE, pos_reg, ONE);
                sts_pkg::CH_RBRACE: tc = make_tok(sts_pkg::KIND_RBRACE, pos_reg, ONE);
                sts_pkg::CH_LBRACK: tc = make_tok(sts_pkg::KIND_LBRACK, pos_reg, ONE);
                sts_pkg::CH_RBRACK: tc = make_tok(sts_pkg::KIND_RBRACK, pos_reg, ONE);
                sts_pkg::CH_COMMA:  tc = make_tok(sts_pkg::KIND_COMMA, pos_reg, ONE);
                sts_pkg::CH_DOT:    tc = make_tok(sts_pkg::KIND_DOT, pos_reg, ONE);
                sts_pkg::CH_SEMI:   tc = make_tok(sts_pkg::KIND_SEMI, pos_reg, ONE);
                sts_pkg::CH_MINUS:  tc = make_tok(sts_pkg::KIND_MINUS, pos_reg, ONE);
                sts_pkg::CH_PLUS:   tc = make_tok(sts_pkg::KIND_PLUS, pos_reg, ONE);
                sts_pkg::CH_STAR:   tc = make_tok(sts_pkg::KIND_STAR, pos_reg, ONE);
                sts_pkg::CH_SLASH, sts_pkg::CH_BANG, sts_pkg::CH_EQ, sts_pkg::CH_GT,
                sts_pkg::CH_LT, sts_pkg::CH_QUOTE:
                begin
                    vc         = 1'b0;
                    start_next = pos_reg;
                    len_next   = ONE;
                    unique case (in_byte)
                        sts_pkg::CH_SLASH: mode_next = sts_pkg::MODE_SLASH;
                        sts_pkg::CH_BANG:  mode_next = sts_pkg::MODE_BANG;
                        sts_pkg::CH_EQ:    mode_next = sts_pkg::MODE_EQUAL;
                        sts_pkg::CH_GT:    mode_next = sts_pkg::MODE_GREATER;
                        sts_pkg::CH_LT:    mode_next = sts_pkg::MODE_LESS;
                        default:           mode_next = sts_pkg::MODE_STRING;
                    endcase
                end
                [sts_pkg::CH_0:sts_pkg::CH_9]:
                begin
                    vc         = 1'b0;
                    start_next = pos_reg;
                    len_next   = ONE;
                    frac_next  = 1'b0;
                    mode_next  = sts_pkg::MODE_NUMBER;
                end
                [sts_pkg::CH_LA:sts_pkg::CH_LZ], [sts_pkg::CH_UA:sts_pkg::CH_UZ],
                sts_pkg::CH_USCORE:
                begin
                    vc         = 1'b0;
                    start_next = pos_reg;
                    len_next   = ONE;
                    mode_next  = sts_pkg::MODE_IDENT;
                    wr_en      = 1'b1;
                    wr_idx     = '0;
                end
                default:
                    tc = make_tok(sts_pkg::KIND_INVALID, pos_reg, ONE);
            endcase
        end

        if (ended)
        begin
            mode_next = sts_pkg::MODE_IDLE;
            pos_next  = '0;
            frac_next = 1'b0;
        end
    end

    // compact: b only ever comes with a
    always_comb
    begin
        bundle.count = 2'({1'b0, va} + {1'b0, vb} + {1'b0, vc});
        bundle.tok0  = va ? ta : tc;
        bundle.tok1  = vb ? tb : tc;
        bundle.tok2  = tc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= sts_pkg::MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            frac_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            frac_reg  <= frac_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            prefix_reg[wr_idx] <= in_byte;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sts_fifo.sv
// Short queue of token bundles between the scanner and the output stage.
`default_nettype none

module sts_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire sts_pkg::bundle_t  wr_data,
    output logic                   full,
    input  wire logic              rd_en,
    output sts_pkg::bundle_t       rd_data,
    output logic                   not_empty
);

    localparam logic [sts_pkg::FIFO_CNT_BITS-1:0] DEPTH =
        sts_pkg::FIFO_CNT_BITS'(sts_pkg::FIFO_DEPTH);

    sts_pkg::bundle_t                  store_reg [sts_pkg::FIFO_DEPTH];
    logic [sts_pkg::FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sts_pkg::FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sts_pkg::FIFO_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                              do_wr, do_rd;

    assign full      = (cnt_reg == DEPTH);
    assign not_empty = (cnt_reg != '0);
    assign rd_data   = store_reg[rd_ptr_reg];
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sts_emit.sv
// Back end: hands out the tokens of the head bundle one beat at a time.
`default_nettype none

module sts_emit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sts_pkg::bundle_t  head,
    input  wire logic              head_valid,
    output logic                   head_pop,
    input  wire logic              pop,
    output logic                   empty,
    output logic [5:0]             token_kind,
    output logic [15:0]            token_start,
    output logic [15:0]            token_length,
    output logic                   last_of_run
);

    logic [1:0]      idx_reg, idx_next;
    sts_pkg::token_t tok;
    logic            take;

    always_comb
    begin
        case (idx_reg)
            2'd0:    tok = head.tok0;
            2'd1:    tok = head.tok1;
            default: tok = head.tok2;
        endcase
    end

    assign empty        = !head_valid;
    assign token_kind   = tok.kind;
    assign token_start  = tok.start;
    assign token_length = tok.length;
    assign last_of_run  = (idx_reg == (head.count - 2'd1));
    assign take         = pop && head_valid;
    assign head_pop     = take && last_of_run;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = last_of_run ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/source_token_scanner_core.sv
// Top level of the streaming token scanner: scanner, bundle queue and output stage.
//
//  channel  | ports                                              | handshake
//  ---------+----------------------------------------------------+-------------------
//  input    | in_byte                                            | push / full
//  tokens   | token_kind, token_start, token_length, last_of_run | pop / empty
//
//  One byte is taken per cycle while the four-entry bundle queue has room; the
//  scanner decides each byte combinationally. Each byte yields zero to three
//  tokens, handed out one per beat by the output stage, so the sustained rate is
//  set by the token count per byte and by pop. A token is shown once its bundle
//  is queued and older tokens are popped. Reset clears scan state and the queue.
`default_nettype none

module source_token_scanner_core #(
    parameter int POSITION_BITS = 16,
    parameter int KEYWORD_BYTES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  in_byte,
    input  wire logic        pop,
    output logic             empty,
    output logic [5:0]       token_kind,
    output logic [15:0]      token_start,
    output logic [15:0]      token_length,
    output logic             last_of_run
);

    logic             accept;
    sts_pkg::bundle_t bundle;
    sts_pkg::bundle_t head;
    logic             head_valid;
    logic             head_pop;

    assign accept = push && !full;

    sts_scan #(
        .POSITION_BITS (POSITION_BITS),
        .KEYWORD_BYTES (KEYWORD_BYTES)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .bundle  (bundle)
    );

    sts_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept && (bundle.count != 2'd0)),
        .wr_data   (bundle),
        .full      (full),
        .rd_en     (head_pop),
        .rd_data   (head),
        .not_empty (head_valid)
    );

    sts_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .head_pop     (head_pop),
        .pop          (pop),
        .empty        (empty),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the streaming token scanner core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sts_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BYTES = 500;
    localparam int HOLD_AT_BYTE = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } token_rec_t;

    typedef struct packed {
        logic [7:0] b;
        logic       chk;
        token_rec_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n   = 1'b0;
    logic        push    = 1'b0;
    logic [7:0]  in_byte = 8'h00;
    logic        pop     = 1'b0;
    logic        full;
    logic        empty;
    logic [5:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;

    source_token_scanner_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .pop         (pop),
        .empty       (empty),
        .token_kind  (token_kind),
        .token_start (token_start),
        .token_length(token_length),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // scanner state as the lexer predicts it
    mode_t       lx_mode  = MODE_IDLE;
    logic [15:0] lx_pos   = '0;
    logic [15:0] lx_start = '0;
    logic [15:0] lx_len   = '0;
    logic        lx_frac  = 1'b0;
    logic [7:0]  lx_prefix [8] = '{default: 8'h00};

    token_rec_t  stage [3];
    int          stage_n;

    token_rec_t  tokens_due [$];
    stim_row_t   stim_q [$];
    int          bytes_taken    = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    function automatic logic [15:0] sat16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic digit_ch(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic letter_ch(input logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ))
            || (c == CH_USCORE);
    endfunction

    function automatic void stage_tok(input logic [5:0] k, input logic [15:0] s,
                                      input logic [15:0] l);
        if (stage_n < 3)
        begin
            stage[stage_n].kind   = k;
            stage[stage_n].start  = s;
            stage[stage_n].length = l;
            stage[stage_n].last   = 1'b0;
            stage_n++;
        end
    endfunction

    function automatic void open_tok(input mode_t m);
        lx_mode  = m;
        lx_start = lx_pos;
        lx_len   = 16'd1;
    endfunction

    // whole-word match only; prefix bytes are alphanumeric so no zero byte aliases
    function automatic logic [5:0] lex_word_kind();
        logic [63:0] w;
        w = '0;
        if (lx_len > 16'd8)
            return KIND_IDENT;
        for (int j = 0; j < lx_len; j++)
            w = {w[55:0], lx_prefix[j]};
        case (w)
            "and":      return KIND_AND;
            "else":     return KIND_ELSE;
            "false":    return KIND_FALSE;
            "for":      return KIND_FOR;
            "function": return KIND_FUNCTION;
            "if":       return KIND_IF;
            "not":      return KIND_NOT;
            "or":       return KIND_OR;
            "return":   return KIND_RETURN;
            "struct":   return KIND_STRUCT;
            "super":    return KIND_SUPER;
            "this":     return KIND_THIS;
            "true":     return KIND_TRUE;
            "var":      return KIND_VAR;
            "while":    return KIND_WHILE;
            default:    return KIND_IDENT;
        endcase
    endfunction

    // byte seen with nothing open; returns 1 on end of text
    function automatic logic lex_fresh(input logic [7:0] c);
        logic [15:0] p;
        logic        ended;
        p = lx_pos;
        ended = 1'b0;
        lx_mode = MODE_IDLE;
        case (c)
            CH_NUL:
            begin
                stage_tok(KIND_END, p, 16'd1);
                ended = 1'b1;
            end
            CH_SP, CH_TAB, CH_LF, CH_CR: ;
            CH_LPAREN: stage_tok(KIND_LPAREN, p, 16'd1);
            CH_RPAREN: stage_tok(KIND_RPAREN, p, 16'd1);
            CH_LBRACE: stage_tok(KIND_LBRACE, p, 16'd1);
            CH_RBRACE: stage_tok(KIND_RBRACE, p, 16'd1);
            CH_LBRACK: stage_tok(KIND_LBRACK, p, 16'd1);
            CH_RBRACK: stage_tok(KIND_RBRACK, p, 16'd1);
            CH_COMMA:  stage_tok(KIND_COMMA, p, 16'd1);
            CH_DOT:    stage_tok(KIND_DOT, p, 16'd1);
            CH_SEMI:   stage_tok(KIND_SEMI, p, 16'd1);
            CH_MINUS:  stage_tok(KIND_MINUS, p, 16'd1);
            CH_PLUS:   stage_tok(KIND_PLUS, p, 16'd1);
            CH_STAR:   stage_tok(KIND_STAR, p, 16'd1);
            CH_SLASH:  open_tok(MODE_SLASH);
            CH_BANG:   open_tok(MODE_BANG);
            CH_EQ:     open_tok(MODE_EQUAL);
            CH_GT:     open_tok(MODE_GREATER);
            CH_LT:     open_tok(MODE_LESS);
            CH_QUOTE:  open_tok(MODE_STRING);
            default:
            begin
                if (digit_ch(c))
                begin
                    open_tok(MODE_NUMBER);
                    lx_frac = 1'b0;
                end
                else if (letter_ch(c))
                begin
                    open_tok(MODE_IDENT);
                    lx_prefix[0] = c;
                end
                else
                    stage_tok(KIND_INVALID, p, 16'd1);
            end
        endcase
        return ended;
    endfunction

    // one accepted byte: advance the lexer and queue the tokens it yields
    task automatic lex_byte(input logic [7:0] c, output int produced);
        logic       fresh;
        logic       pair;
        logic       ended;
        logic [5:0] one_k;
        logic [5:0] two_k;
        fresh = 1'b0;
        pair = 1'b0;
        one_k = KIND_INVALID;
        two_k = KIND_INVALID;
        stage_n = 0;
        case (lx_mode)
            MODE_IDENT:
                if (letter_ch(c) || digit_ch(c))
                begin
                    if (lx_len < 16'd8)
                        lx_prefix[lx_len[2:0]] = c;
                    lx_len = sat16(lx_len);
                end
                else
                begin
                    stage_tok(lex_word_kind(), lx_start, lx_len);
                    fresh = 1'b1;
                end
            MODE_NUMBER:
                if (digit_ch(c))
                    lx_len = sat16(lx_len);
                else if (c == CH_DOT && !lx_frac)
                begin
                    lx_len = sat16(lx_len);
                    lx_mode = MODE_NUMDOT;
                end
                else
                begin
                    stage_tok(KIND_NUMBER, lx_start, lx_len);
                    fresh = 1'b1;
                end
            MODE_NUMDOT:
                if (digit_ch(c))
                begin
                    lx_frac = 1'b1;
                    lx_len = sat16(lx_len);
                    lx_mode = MODE_NUMBER;
                end
                else
                begin
                    // the dot did not join: number without it, then the dot itself
                    stage_tok(KIND_NUMBER, lx_start, (lx_len > 0) ? lx_len - 16'd1 : 16'd0);
                    stage_tok(KIND_DOT, (lx_pos > 0) ? lx_pos - 16'd1 : 16'd0, 16'd1);
                    fresh = 1'b1;
                end
            MODE_STRING:
                if (c == CH_NUL)
                begin
                    stage_tok(KIND_INVALID, lx_start, lx_len);
                    fresh = 1'b1;
                end
                else
                begin
                    lx_len = sat16(lx_len);
                    if (c == CH_QUOTE)
                    begin
                        stage_tok(KIND_STRING, lx_start, lx_len);
                        lx_mode = MODE_IDLE;
                    end
                end
            MODE_COMMENT:
                if (c == CH_LF || c == CH_NUL)
                begin
                    stage_tok(KIND_COMMENT, lx_start, lx_len);
                    fresh = 1'b1;
                end
                else
                    lx_len = sat16(lx_len);
            MODE_SLASH:
                if (c == CH_SLASH)
                begin
                    lx_len = 16'd2;
                    lx_mode = MODE_COMMENT;
                end
                else
                begin
                    stage_tok(KIND_SLASH, lx_start, 16'd1);
                    fresh = 1'b1;
                end
            MODE_BANG:
            begin
                pair = 1'b1;
                one_k = KIND_INVALID;
                two_k = KIND_BANG_EQ;
            end
            MODE_EQUAL:
            begin
                pair = 1'b1;
                one_k = KIND_EQ;
                two_k = KIND_EQ_EQ;
            end
            MODE_GREATER:
            begin
                pair = 1'b1;
                one_k = KIND_GT;
                two_k = KIND_GT_EQ;
            end
            MODE_LESS:
            begin
                pair = 1'b1;
                one_k = KIND_LT;
                two_k = KIND_LT_EQ;
            end
            default: fresh = 1'b1;
        endcase

        if (pair)
        begin
            if (c == CH_EQ)
            begin
                stage_tok(two_k, lx_start, 16'd2);
                lx_mode = MODE_IDLE;
            end
            else
            begin
                stage_tok(one_k, lx_start, 16'd1);
                fresh = 1'b1;
            end
        end

        ended = fresh ? lex_fresh(c) : 1'b0;
        if (ended)
        begin
            lx_mode = MODE_IDLE;
            lx_pos = '0;
            lx_frac = 1'b0;
        end
        else
            lx_pos = sat16(lx_pos);

        for (int k = 0; k < stage_n; k++)
        begin
            stage[k].last = (k == stage_n - 1);
            tokens_due.push_back(stage[k]);
        end
        produced = stage_n;
    endtask

    task automatic flag_error(input string what, input token_rec_t want, input token_rec_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s at cycle %0d: expected kind %0d start %0d len %0d last %0d, %s",
                     what, cycle_count, want.kind, want.start, want.length, want.last,
                     $sformatf("got kind %0d start %0d len %0d last %0d",
                               got.kind, got.start, got.length, got.last));
    endtask

    // ---- stimulus table ----
    task automatic put_byte(input logic [7:0] b);
        stim_row_t row;
        row = '0;
        row.b = b;
        stim_q.push_back(row);
    endtask

    // row whose final token is known by inspection
    task automatic put_checked(input logic [7:0] b, input logic [5:0] k,
                               input logic [15:0] s, input logic [15:0] l);
        stim_row_t row;
        row.b = b;
        row.chk = 1'b1;
        row.want.kind = k;
        row.want.start = s;
        row.want.length = l;
        row.want.last = 1'b1;
        stim_q.push_back(row);
    endtask

    task automatic put_text(input string s);
        for (int j = 0; j < s.len(); j++)
            put_byte(s[j]);
    endtask

    function automatic string kw_spelling(input int i);
        case (i)
            0:  return "and";
            1:  return "else";
            2:  return "false";
            3:  return "for";
            4:  return "function";
            5:  return "if";
            6:  return "not";
            7:  return "or";
            8:  return "return";
            9:  return "struct";
            10: return "super";
            11: return "this";
            12: return "true";
            13: return "var";
            default: return "while";
        endcase
    endfunction

    function automatic logic [7:0] rand_word_ch(input logic first);
        int r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26)
            return CH_LA + 8'(r);
        if (r < 52)
            return CH_UA + 8'(r - 26);
        if (r == 52)
            return CH_USCORE;
        return CH_0 + 8'(r - 53);
    endfunction

    task automatic put_digits(input int n);
        for (int j = 0; j < n; j++)
            put_byte(CH_0 + 8'($urandom_range(0, 9)));
    endtask

    // one well-formed token, a variant of one, or noise, then maybe whitespace
    task automatic gen_token();
        string      s;
        int         r;
        int         v;
        int         n;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            s = kw_spelling($urandom_range(0, 14));
            v = $urandom_range(0, 4);
            if (v == 2 && s.len() > 1)
                s = s.substr(0, s.len() - 2);
            if (v == 4)
            begin
                put_byte(s[0] - 8'h20);
                put_text(s.substr(1, s.len() - 1));
            end
            else
                put_text(s);
            if (v == 3)
                put_byte(rand_word_ch(1'b0));
        end
        else if (r < 32)
        begin
            n = $urandom_range(1, 12);
            put_byte(rand_word_ch(1'b1));
            for (int j = 1; j < n; j++)
                put_byte(rand_word_ch(1'b0));
        end
        else if (r < 44)
        begin
            put_digits($urandom_range(1, 4));
            v = $urandom_range(0, 3);
            if (v != 0)
                put_byte(CH_DOT);
            if (v == 1 || v == 2)
                put_digits($urandom_range(1, 3));
            if (v == 2)
            begin
                put_byte(CH_DOT);
                put_digits(1);
            end
        end
        else if (r < 52)
        begin
            put_byte(CH_QUOTE);
            n = $urandom_range(0, 6);
            for (int j = 0; j < n; j++)
            begin
                do
                    b = 8'($urandom_range(1, 255));
                while (b == CH_QUOTE);
                put_byte(b);
            end
            put_byte(($urandom_range(0, 5) == 0) ? CH_NUL : CH_QUOTE);
        end
        else if (r < 58)
        begin
            put_byte(CH_SLASH);
            put_byte(CH_SLASH);
            n = $urandom_range(0, 8);
            for (int j = 0; j < n; j++)
            begin
                do
                    b = 8'($urandom_range(1, 255));
                while (b == CH_LF);
                put_byte(b);
            end
            put_byte(($urandom_range(0, 4) == 0) ? CH_NUL : CH_LF);
        end
        else if (r < 72)
        begin
            case ($urandom_range(0, 8))
                0: put_text("!=");
                1: put_text("==");
                2: put_text("<=");
                3: put_text(">=");
                4: put_text("=");
                5: put_text("<");
                6: put_text(">");
                7: put_text("!");
                default: put_text("/");
            endcase
        end
        else if (r < 86)
        begin
            s = "(){}[],.;-+*";
            put_byte(s[$urandom_range(0, s.len() - 1)]);
        end
        else if (r < 94)
            put_byte(8'($urandom % 255) + 8'd1);
        else
            put_byte(CH_NUL);

        if ($urandom_range(0, 1) == 0)
        begin
            s = " \t\n\r";
            put_byte(s[$urandom_range(0, 3)]);
        end
    endtask

    task automatic build_stimulus();
        int base;
        // directed: lone bang, keyword, number then two dots, comment, open string,
        // top-bit bytes, two-char operator, fraction then dot
        put_checked(CH_LPAREN, KIND_LPAREN, 16'd0, 16'd1);
        put_byte(CH_BANG);
        put_checked(CH_LA, KIND_INVALID, 16'd1, 16'd1);
        put_byte("n");
        put_byte("d");
        put_checked(CH_SP, KIND_AND, 16'd2, 16'd3);
        put_byte("1");
        put_byte(CH_DOT);
        put_checked(CH_DOT, KIND_DOT, 16'd8, 16'd1);
        put_byte(CH_SLASH);
        put_byte(CH_SLASH);
        put_byte(8'hFF);
        put_checked(CH_LF, KIND_COMMENT, 16'd9, 16'd3);
        put_byte(CH_QUOTE);
        put_byte("q");
        put_checked(CH_NUL, KIND_END, 16'd15, 16'd1);
        put_checked(8'h80, KIND_INVALID, 16'd0, 16'd1);
        put_byte(CH_GT);
        put_checked(CH_EQ, KIND_GT_EQ, 16'd1, 16'd2);
        put_byte("2");
        put_byte(CH_DOT);
        put_byte("5");
        put_checked(CH_DOT, KIND_DOT, 16'd6, 16'd1);
        put_checked(CH_NUL, KIND_END, 16'd7, 16'd1);

        base = stim_q.size();
        while (stim_q.size() < base + RANDOM_BYTES)
            gen_token();
        put_byte(CH_NUL);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 0;
        if (r < 97)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---- byte sender, lexer and end of run ----
    initial
    begin
        int  gap;
        int  produced;
        logic calm;
        token_rec_t got_last;
        calm = 1'b0;
        build_stimulus();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < stim_q.size(); i++)
        begin
            if (i % 64 == 0)
                calm = ($urandom_range(0, 2) == 0);
            gap = calm ? 0 : gap_len();
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            push <= 1'b1;
            in_byte <= stim_q[i].b;
            @(posedge clk);
            while (full)
                @(posedge clk);
            bytes_taken++;
            lex_byte(stim_q[i].b, produced);
            if (stim_q[i].chk)
            begin
                got_last = (produced > 0) ? tokens_due[$] : '0;
                if (got_last !== stim_q[i].want)
                    flag_error("table row disagrees", stim_q[i].want, got_last);
            end
        end
        push <= 1'b0;

        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && tokens_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ---- token receiver and checker ----
    initial
    begin
        int  stall;
        int  hold;
        int  phase;
        logic held;
        logic calm;
        token_rec_t got;
        token_rec_t want;
        stall = 0;
        hold = 0;
        phase = 0;
        held = 1'b0;
        calm = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                got.kind = token_kind;
                got.start = token_start;
                got.length = token_length;
                got.last = last_of_run;
                if (tokens_due.size() == 0)
                    flag_error("unexpected token", '0, got);
                else
                begin
                    want = tokens_due.pop_front();
                    if (got !== want)
                        flag_error("token mismatch", want, got);
                end
            end

            // one long hold-off so the queue fills and the sender sees full
            if (!held && bytes_taken >= HOLD_AT_BYTE)
            begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            phase++;
            if (phase % 64 == 0)
                calm = ($urandom_range(0, 2) == 0);

            if (hold > 0)
            begin
                hold--;
                pop <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else
            begin
                stall = calm ? 0 : gap_len();
                pop <= (stall == 0);
            end
        end
    end

    // ---- watchdog ----
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule

>>> source_token_scanner_core.f
rtl/core/sts_pkg.sv
rtl/core/sts_scan.sv
rtl/core/sts_fifo.sv
rtl/core/sts_emit.sv
rtl/core/source_token_scanner_core.sv
tb/tb_top.sv
